FILE: src/gnc_pkg.sv
// gnc_pkg: shared constants and types for the global norm gradient clipper
// used by gnc_sqrt, gnc_div and global_norm_gradient_clip
// no dependencies
package gnc_pkg;

  // fixed point format of gradient elements and of the scale factor
  localparam int FRAC_BITS  = 16;
  localparam int GRAD_W     = 32;
  localparam int NORM_W     = 32;
  localparam int MAXN_W     = 31;
  localparam int SUM_W      = 64;
  localparam int SCALE_W    = FRAC_BITS + 1;
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << FRAC_BITS;

  // square root: one result bit per step
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  // scale divide: one quotient bit per step
  localparam int DIV_CNT_W  = $clog2(FRAC_BITS);

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

FILE: src/gnc_sqrt.sv
// gnc_sqrt: iterative floor square root of the 64-bit sum of squares
// one root bit per cycle; depends on gnc_pkg
module gnc_sqrt
  import gnc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   radicand,
  output logic [NORM_W-1:0]  root,
  output unit_status_t       status
);

  logic [SUM_W-1:0]      rad;
  logic [NORM_W+1:0]     rem;
  logic [SQRT_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;

  logic [NORM_W+3:0]     rem_sh;
  logic [NORM_W+3:0]     trial;
  logic                  fits;

  // one digit step: bring down two radicand bits and try root*4+1
  assign rem_sh = {rem, rad[SUM_W-1:SUM_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[SUM_W-3:0], 2'b00};
      if (fits) begin
        rem  <= NORM_W'(0) + (rem_sh[NORM_W+1:0] - trial[NORM_W+1:0]);
        root <= {root[NORM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[NORM_W+1:0];
        root <= {root[NORM_W-2:0], 1'b0};
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: src/gnc_div.sv
// gnc_div: iterative divide giving floor((threshold << FRAC_BITS) / norm)
// for a threshold below norm; one quotient bit per cycle; depends on gnc_pkg
module gnc_div
  import gnc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MAXN_W-1:0]    dividend,
  input  logic [NORM_W-1:0]    divisor,
  output logic [FRAC_BITS-1:0] quotient,
  output unit_status_t         status
);

  logic [NORM_W-1:0]    dvsr;
  logic [NORM_W:0]      rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [NORM_W:0]      rem_sh;
  logic                 fits;

  // restoring step: remainder stays below the divisor
  assign rem_sh = {rem[NORM_W-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, dvsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr     <= divisor;
      rem      <= {{(NORM_W + 1 - MAXN_W){1'b0}}, dividend};
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem      <= rem_sh - {1'b0, dvsr};
        quotient <= {quotient[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: src/global_norm_gradient_clip.sv
// global_norm_gradient_clip: top level of the global norm gradient clipper
// depends on gnc_pkg, gnc_sqrt and gnc_div
//
// Usage
//   Input items are taken with start while busy is low: mode, grad_value, is_last.
//   mode 0 adds the element's square to a saturating 64-bit sum; on is_last the
//   norm (floor square root) is found, the scale factor and clip flag are set
//   and a norm report item (kind 0) is produced. mode 1 multiplies the element
//   by the current scale factor and produces a scaled item (kind 1).
//   Results appear for one cycle with done high; the receiver cannot stall.
//   the clipping threshold is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is high while the block is idle.
// Sequence
//   scale items and non-last measure items pass through the shared multiplier
//   and the accumulate step; a new item is taken only once busy has fallen,
//   and the result strobe of a scale item comes as busy falls.
//   a last measure item then runs the bitwise square root and, when clipping
//   applies, the bitwise divide before its norm report item is produced.
// Reset
//   rst clears the sum, sets the scale to one, clip flag and threshold to zero.
module global_norm_gradient_clip
  import gnc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode,
  input  logic signed [GRAD_W-1:0] grad_value,
  input  logic                     is_last,
  output logic                     done,
  output logic                     kind,
  output logic signed [GRAD_W-1:0] scaled_value,
  output logic [NORM_W-1:0]        norm_value,
  output logic                     clipped,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [MAXN_W-1:0]        cfg_data
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL      = 3'd1;
  localparam logic [2:0] ST_ACC      = 3'd2;
  localparam logic [2:0] ST_SQ_GO    = 3'd3;
  localparam logic [2:0] ST_SQ_WAIT  = 3'd4;
  localparam logic [2:0] ST_DECIDE   = 3'd5;
  localparam logic [2:0] ST_DIV_WAIT = 3'd6;

  logic [2:0]                state;
  logic [MAXN_W-1:0]         clip_threshold;
  logic [SUM_W-1:0]          square_sum;
  logic [SCALE_W-1:0]        scale_val;
  logic                      clip_active;

  logic                      item_mode;
  logic signed [GRAD_W-1:0]  item_grad;
  logic                      item_last;
  logic signed [2*GRAD_W+1:0] prod;
  logic [NORM_W-1:0]         norm;

  logic [GRAD_W-1:0]         mag;
  logic signed [GRAD_W:0]    mul_a;
  logic signed [GRAD_W:0]    mul_b;
  logic [SUM_W:0]            sum_ext;
  logic signed [2*GRAD_W+1:0] prod_sh;
  logic                      accept;
  logic                      need_clip;

  logic                      sqrt_start;
  logic [NORM_W-1:0]         sqrt_root;
  unit_status_t              sqrt_sts;
  logic                      div_start;
  logic [FRAC_BITS-1:0]      div_quo;
  unit_status_t              div_sts;

  assign busy      = state != ST_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // shared multiplier operands: square in measure mode, scale in scale mode
  assign mag   = item_grad[GRAD_W-1] ? GRAD_W'(-item_grad) : GRAD_W'(item_grad);
  assign mul_a = item_mode ? {item_grad[GRAD_W-1], item_grad} : $signed({1'b0, mag});
  assign mul_b = item_mode ? $signed({{(GRAD_W + 1 - SCALE_W){1'b0}}, scale_val})
                           : $signed({1'b0, mag});

  // saturating accumulate and floored scale
  assign sum_ext   = {1'b0, square_sum} + {1'b0, prod[SUM_W-1:0]};
  assign prod_sh   = prod >>> FRAC_BITS;
  assign need_clip = (clip_threshold != '0) && (norm > {1'b0, clip_threshold});

  assign sqrt_start = state == ST_SQ_GO;
  assign div_start  = (state == ST_DECIDE) && need_clip;

  gnc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (square_sum),
    .root     (sqrt_root),
    .status   (sqrt_sts)
  );

  gnc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clip_threshold),
    .divisor  (norm),
    .quotient (div_quo),
    .status   (div_sts)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      clip_threshold <= cfg_data;
    end
  end

  // item capture, multiplier register and norm register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode <= mode;
      item_grad <= grad_value;
      item_last <= is_last;
    end
    if (state == ST_MUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_SQ_WAIT && sqrt_sts.done) begin
      norm <= sqrt_root;
    end
  end

  // sequencer and clipping state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      square_sum  <= '0;
      scale_val   <= SCALE_ONE;
      clip_active <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (item_mode) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            square_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            state      <= item_last ? ST_SQ_GO : ST_IDLE;
          end
        end
        ST_SQ_GO: begin
          square_sum <= '0;
          state      <= ST_SQ_WAIT;
        end
        ST_SQ_WAIT: begin
          if (sqrt_sts.done) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (need_clip) begin
            state <= ST_DIV_WAIT;
          end else begin
            scale_val   <= SCALE_ONE;
            clip_active <= 1'b0;
            done        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        ST_DIV_WAIT: begin
          if (div_sts.done) begin
            scale_val   <= {1'b0, div_quo};
            clip_active <= 1'b1;
            done        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ST_ACC && item_mode) begin
      kind         <= 1'b1;
      scaled_value <= prod_sh[GRAD_W-1:0];
      norm_value   <= '0;
      clipped      <= clip_active;
    end else if (state == ST_DECIDE && !need_clip) begin
      kind         <= 1'b0;
      scaled_value <= '0;
      norm_value   <= norm;
      clipped      <= 1'b0;
    end else if (state == ST_DIV_WAIT && div_sts.done) begin
      kind         <= 1'b0;
      scaled_value <= '0;
      norm_value   <= norm;
      clipped      <= 1'b1;
    end
  end

  // checks
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not start work");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(sqrt_sts.busy && div_sts.busy))
    else $error("square root and divide running together");

  a_scale_le_one: assert property (@(posedge clk) disable iff (rst)
    scale_val <= SCALE_ONE)
    else $error("scale factor above one");

endmodule

FILE: tb/sv/tb_global_norm_gradient_clip.sv
// tb_global_norm_gradient_clip: self-checking testbench for the global norm gradient clipper
// runs a directed table then random vectors and checks each result against a local model or a typed table entry
// depends on gnc_pkg and global_norm_gradient_clip
module tb_global_norm_gradient_clip;
  timeunit 1ns;
  timeprecision 1ps;

  import gnc_pkg::*;

  // item and result codes
  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_SCALE   = 1'b1;
  localparam logic KIND_NORM    = 1'b0;
  localparam logic KIND_SCALED  = 1'b1;

  localparam int SETTLE_CYCLES  = 80;      // covers root plus divide after a silent item
  localparam int CYCLE_LIMIT    = 400000;
  localparam int ITEMS_PER_SET  = 56;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic              kind;
    logic [GRAD_W-1:0] scaled;
    logic [NORM_W-1:0] norm;
    logic              clip;
  } clip_result_t;

  typedef enum logic {ROW_ITEM, ROW_LIMIT} row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic              m;
    logic [GRAD_W-1:0] g;
    logic              l;
    logic              typed;
    clip_result_t      res;
  } stim_row_t;

  localparam clip_result_t NO_RES = '0;
  localparam int NUM_ROWS = 25;

  // directed table: typed results only where they are plain to see
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // scale pass straight after reset uses a factor of one
    '{ROW_ITEM, MODE_SCALE, 32'h7FFF_FFFF, 1'b0, 1'b1,
      '{KIND_SCALED, 32'h7FFF_FFFF, 32'h0, 1'b0}},
    // is_last ignored in scale mode
    '{ROW_ITEM, MODE_SCALE, 32'h8000_0000, 1'b1, 1'b1,
      '{KIND_SCALED, 32'h8000_0000, 32'h0, 1'b0}},
    '{ROW_ITEM, MODE_MEASURE, 32'h0000_0000, 1'b1, 1'b1,
      '{KIND_NORM, 32'h0, 32'h0, 1'b0}},
    '{ROW_ITEM, MODE_MEASURE, 32'h8000_0000, 1'b1, 1'b1,
      '{KIND_NORM, 32'h0, 32'h8000_0000, 1'b0}},
    // element not last: no result
    '{ROW_ITEM, MODE_MEASURE, 32'h0001_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'hFFFF_0000, 1'b1, 1'b0, NO_RES},
    // four most negative elements overflow the sum, clipping disabled
    '{ROW_ITEM, MODE_MEASURE, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h8000_0000, 1'b1, 1'b1,
      '{KIND_NORM, 32'h0, 32'hFFFF_FFFF, 1'b0}},
    // largest threshold, saturated sum is still above it
    '{ROW_LIMIT, MODE_MEASURE, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h8000_0000, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_SCALE, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_SCALE, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    // norm equal to threshold does not clip, one step above does
    '{ROW_LIMIT, MODE_MEASURE, 32'h0001_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h0001_0000, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h0001_0001, 1'b1, 1'b0, NO_RES},
    // negative products round towards minus infinity
    '{ROW_ITEM, MODE_SCALE, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_SCALE, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
    // smallest nonzero threshold
    '{ROW_LIMIT, MODE_MEASURE, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_MEASURE, 32'h0000_0100, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, MODE_SCALE, 32'h1234_5678, 1'b1, 1'b0, NO_RES}
  };

  localparam logic [MAXN_W-1:0] FIXED_LIMITS [6] = '{
    31'h7FFF_FFFF, 31'h0000_0001, 31'h0001_0000, 31'h0000_0000, 31'h0000_0100, 31'h0100_0000
  };

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     mode;
  logic signed [GRAD_W-1:0] grad_value;
  logic                     is_last;
  logic                     done;
  logic                     kind;
  logic signed [GRAD_W-1:0] scaled_value;
  logic [NORM_W-1:0]        norm_value;
  logic                     clipped;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [MAXN_W-1:0]        cfg_data;

  // model state
  logic [SUM_W-1:0]   square_acc;
  logic [SCALE_W-1:0] scale_now;
  logic               clip_now;
  logic [MAXN_W-1:0]  norm_limit;

  clip_result_t awaited_results [$];
  clip_result_t seen_result;
  clip_result_t want_result;
  int           fault_count = 0;
  int           cycle_count = 0;

  global_norm_gradient_clip dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .grad_value   (grad_value),
    .is_last      (is_last),
    .done         (done),
    .kind         (kind),
    .scaled_value (scaled_value),
    .norm_value   (norm_value),
    .clipped      (clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // floor square root, one result bit at a time from the top
  function automatic logic [NORM_W-1:0] floor_root(input logic [SUM_W-1:0] x);
    logic [NORM_W-1:0] r;
    logic [NORM_W-1:0] trial;
    r = '0;
    for (int b = NORM_W - 1; b >= 0; b--) begin
      trial = r | (NORM_W'(1) << b);
      if (SUM_W'(trial) * SUM_W'(trial) <= x) r = trial;
    end
    return r;
  endfunction

  // advance the clipper state by one item, returns 1 when a result is due
  function automatic logic clip_step(input logic m, input logic [GRAD_W-1:0] g,
                                     input logic l, output clip_result_t res);
    logic [SUM_W:0]         wide;
    logic [SUM_W-1:0]       mag;
    logic [NORM_W-1:0]      root;
    logic signed [SUM_W-1:0] g_ext;
    logic signed [SUM_W-1:0] f_ext;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] shifted;
    res = '0;
    g_ext = {{(SUM_W-GRAD_W){g[GRAD_W-1]}}, g};
    if (m == MODE_MEASURE) begin
      mag = g[GRAD_W-1] ? SUM_W'(0) - g_ext : g_ext;
      wide = {1'b0, square_acc} + {1'b0, mag * mag};
      square_acc = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
      if (!l) return 1'b0;
      root = floor_root(square_acc);
      if (norm_limit != '0 && root > norm_limit) begin
        scale_now = SCALE_W'((SUM_W'(norm_limit) << FRAC_BITS) / SUM_W'(root));
        clip_now = 1'b1;
      end else begin
        scale_now = SCALE_ONE;
        clip_now = 1'b0;
      end
      square_acc = '0;
      res.kind = KIND_NORM;
      res.norm = root;
      res.clip = clip_now;
    end else begin
      f_ext = SUM_W'(scale_now);
      prod = g_ext * f_ext;
      shifted = prod >>> FRAC_BITS;
      res.kind = KIND_SCALED;
      res.scaled = shifted[GRAD_W-1:0];
      res.clip = clip_now;
    end
    return 1'b1;
  endfunction

  task automatic note_fault(input string what, input clip_result_t exp_r,
                            input clip_result_t got_r);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("%s at cycle %0d: expected kind %0d scaled %h norm %h clipped %0d",
               what, cycle_count, exp_r.kind, exp_r.scaled, exp_r.norm, exp_r.clip);
      $display("  got kind %0d scaled %h norm %h clipped %0d",
               got_r.kind, got_r.scaled, got_r.norm, got_r.clip);
    end
  endtask

  // result checker: every strobed result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      seen_result = {kind, scaled_value, norm_value, clipped};
      if (awaited_results.size() == 0) begin
        note_fault("unexpected result", NO_RES, seen_result);
      end else begin
        want_result = awaited_results.pop_front();
        if (seen_result.kind !== want_result.kind || seen_result.scaled !== want_result.scaled ||
            seen_result.norm !== want_result.norm || seen_result.clip !== want_result.clip)
          note_fault("mismatch", want_result, seen_result);
      end
    end
  end

  // present one item and hold it until accepted
  task automatic push_item(input logic m, input logic [GRAD_W-1:0] g, input logic l,
                           input logic typed, input clip_result_t typed_res);
    clip_result_t res;
    logic         due;
    start      <= 1'b1;
    mode       <= m;
    grad_value <= g;
    is_last    <= l;
    do @(posedge clk); while (busy);
    due = clip_step(m, g, l, res);
    if (due) awaited_results.push_back(typed ? typed_res : res);
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // hold off until every expected result has come
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // threshold write, only with the block idle
  task automatic write_limit(input logic [MAXN_W-1:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    norm_limit = v;
  endtask

  // gradient element of a given magnitude class
  function automatic logic [GRAD_W-1:0] rand_grad(input int cls);
    logic [GRAD_W-1:0] v;
    case (cls)
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0003_FFFF);
      2: v = $urandom_range(0, 32'h00FF_FFFF);
      default: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h0000_0001;
          default: v = '0;
        endcase
      end
    endcase
    if (cls == 1 || cls == 2) begin
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  // random items under one threshold: mostly whole measure-then-scale vectors
  task automatic random_items(input int pct, input int budget);
    int                sent;
    int                len;
    int                cls;
    logic [GRAD_W-1:0] vec [$];
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) < 8) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        cls = $urandom_range(3);
        vec.delete();
        for (int k = 0; k < len; k++) vec.push_back(rand_grad(cls));
        // measure pass
        for (int k = 0; k < len; k++) begin
          push_item(MODE_MEASURE, vec[k], k == len - 1, 1'b0, NO_RES);
          sender_gap(pct);
        end
        // scale pass over the same elements
        for (int k = 0; k < len; k++) begin
          push_item(MODE_SCALE, vec[k], 1'($urandom_range(1)), 1'b0, NO_RES);
          sender_gap(pct);
        end
        sent += 2 * len;
      end else begin
        // stray item, any field combination
        push_item(1'($urandom_range(1)), rand_grad($urandom_range(3)),
                  1'($urandom_range(1)), 1'b0, NO_RES);
        sender_gap(pct);
        sent++;
      end
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  // main sequence
  initial begin
    int                idle_pct [3];
    stim_row_t         row;
    logic [MAXN_W-1:0] lim;
    idle_pct = '{17, 59, 0};
    rst        = 1'b1;
    start      = 1'b0;
    mode       = MODE_MEASURE;
    grad_value = '0;
    is_last    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    square_acc = '0;
    scale_now  = SCALE_ONE;
    clip_now   = 1'b0;
    norm_limit = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.op == ROW_LIMIT) begin
        write_limit(row.g[MAXN_W-1:0]);
      end else begin
        push_item(row.m, row.g, row.l, row.typed, row.res);
        sender_gap(17);
      end
    end

    // random part: three idling phases, four thresholds each
    for (int p = 0; p < 3; p++) begin
      for (int s = 0; s < 4; s++) begin
        if (p * 4 + s < 6)
          lim = FIXED_LIMITS[p * 4 + s];
        else
          lim = MAXN_W'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24));
        write_limit(lim);
        random_items(idle_pct[p], ITEMS_PER_SET);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
